FILE: design/srps_pkg.sv
// ----------------------------------------------------------------------------
// srps_pkg: shared constants and types for the step rate pulse scheduler
// Field widths, rate thresholds, interval constants and the divider status.
// ----------------------------------------------------------------------------
package srps_pkg;

  localparam int FIELD_W      = 48;         // time and position port width
  localparam int RATE_W       = 24;         // one signed rate input
  localparam int SUM_W        = RATE_W + 2; // sum of three rates
  localparam int MAG_W        = SUM_W - 1;  // magnitude of the sum
  localparam int IDLE_LIMIT   = 26;         // below this |sum| the axis rests
  localparam int INTERVAL_NUM = 256000000;  // 1e6 us * 256
  localparam int NUM_W        = 28;         // bits of INTERVAL_NUM
  localparam int QUO_W        = 24;         // quotient bits for |sum| >= 26
  localparam int INTERVAL_MIN = 50;         // shortest step interval in us
  localparam int CNT_W        = $clog2(NUM_W);

  localparam int TIME_BITS_DEF     = 48;
  localparam int POSITION_BITS_DEF = 48;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/srps_div.sv
// ----------------------------------------------------------------------------
// srps_div: serial interval divider
// Restoring radix-2 division of the fixed interval numerator by |sum|,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srps_div
  import srps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [QUO_W-1:0] quotient
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [MAG_W-1:0] dvs_r, dvs_nxt;

  logic [MAG_W:0]   part;
  logic [MAG_W+1:0] diff;

  assign part = {rem_r, quo_r[NUM_W-1]};
  assign diff = {1'b0, part} - {2'b00, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = NUM_W'(INTERVAL_NUM);
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // keep the partial remainder when the trial subtract borrows
      if (diff[MAG_W+1]) begin
        rem_nxt = part[MAG_W-1:0];
      end else begin
        rem_nxt = diff[MAG_W-1:0];
      end
      quo_nxt = {quo_r[NUM_W-2:0], ~diff[MAG_W+1]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r[QUO_W-1:0];

endmodule

FILE: design/step_rate_pulse_scheduler.sv
// ----------------------------------------------------------------------------
// step_rate_pulse_scheduler: step pulse scheduler for one stepper axis
// Turns tick beats with signed rates into step pulses, position and due time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat is either a time tick with
//   three signed rates (in_func = 0) or a position load (in_func = 1).
//   Result channel (out_valid/out_ready): exactly one result beat per input
//   beat, in order: step pulse flag, last direction, position, next wake
//   time (all ones when idle) and the idle flag.
//   Sequencing: a tick that issues a step passes S_EVAL, then runs the
//   interval divider in S_DIV, one quotient bit per cycle, then S_DONE;
//   loads, idle ticks and ticks not yet due go from S_EVAL to S_DONE.
//   The block takes no new beat until the sequencer has written the
//   result of the last one to the result register; in_ready is high only
//   while the sequencer waits for work.
//   The result register parts the two channels: a new beat is taken while a
//   result waits; a finished result holds in the sequencer until the output
//   register frees, so a stalled receiver stalls the block without loss.
//   Reset: no step pending, position zero, direction forward, no result.
// ----------------------------------------------------------------------------
module step_rate_pulse_scheduler
  import srps_pkg::*;
#(
  parameter int TIME_BITS     = TIME_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [FIELD_W-1:0]        in_now_us,
  input  logic signed [RATE_W-1:0]  in_manual_rate,
  input  logic signed [RATE_W-1:0]  in_goto_rate,
  input  logic signed [RATE_W-1:0]  in_track_rate,
  input  logic                      in_track_on,
  input  logic signed [FIELD_W-1:0] in_load_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_step_pulse,
  output logic                      out_direction,
  output logic signed [FIELD_W-1:0] out_position,
  output logic [FIELD_W-1:0]        out_next_wake_us,
  output logic                      out_idle
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_DONE} state_t;
  typedef enum logic [1:0] {ACT_LOAD, ACT_IDLE, ACT_HOLD, ACT_STEP} act_t;

  state_t state_r, state_nxt;
  act_t   act_r, act_nxt;

  // captured beat
  logic                            func_r, func_nxt;
  logic [TIME_BITS-1:0]            now_r, now_nxt;
  logic signed [SUM_W-1:0]         sum_r, sum_nxt;
  logic signed [POSITION_BITS-1:0] load_r, load_nxt;

  // axis state
  logic [TIME_BITS-1:0]            due_r, due_nxt;
  logic signed [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                            dir_r, dir_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic                      pulse_r, pulse_nxt;
  logic                      odir_r, odir_nxt;
  logic signed [FIELD_W-1:0] opos_r, opos_nxt;
  logic [FIELD_W-1:0]        wake_r, wake_nxt;
  logic                      oidle_r, oidle_nxt;

  // evaluation and divider
  logic                 neg;
  logic [MAG_W-1:0]     mag;
  logic                 below;
  logic [TIME_BITS-1:0] due_m1;
  logic                 is_due;
  logic                 div_start;
  div_stat_t            div_st;
  logic [QUO_W-1:0]     quo;
  logic [QUO_W-1:0]     interval;

  assign neg    = sum_r[SUM_W-1];
  assign mag    = neg ? MAG_W'(-sum_r) : MAG_W'(sum_r);
  assign below  = (mag < MAG_W'(IDLE_LIMIT));
  assign due_m1 = due_r - TIME_BITS'(1);
  assign is_due = (due_r == '0) || (now_r >= due_m1);
  assign interval = (quo < QUO_W'(INTERVAL_MIN)) ? QUO_W'(INTERVAL_MIN) : quo;

  assign div_start = (state_r == S_EVAL) && (act_nxt == ACT_STEP);

  srps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (mag),
    .stat     (div_st),
    .quotient (quo)
  );

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    func_nxt      = func_r;
    now_nxt       = now_r;
    sum_nxt       = sum_r;
    load_nxt      = load_r;
    due_nxt       = due_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r;
    pulse_nxt     = pulse_r;
    odir_nxt      = odir_r;
    opos_nxt      = opos_r;
    wake_nxt      = wake_r;
    oidle_nxt     = oidle_r;

    // drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          now_nxt  = TIME_BITS'(in_now_us);
          sum_nxt  = SUM_W'(in_manual_rate) + SUM_W'(in_goto_rate) +
                     (in_track_on ? SUM_W'(in_track_rate) : SUM_W'(0));
          load_nxt = POSITION_BITS'(in_load_value);
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (func_r) begin
          act_nxt = ACT_LOAD;
        end else if (below) begin
          act_nxt = ACT_IDLE;
        end else if (is_due) begin
          act_nxt = ACT_STEP;
        end else begin
          act_nxt = ACT_HOLD;
        end
        state_nxt = (act_nxt == ACT_STEP) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold here until the result register is free
        if (!out_valid_r || out_ready) begin
          pulse_nxt = 1'b0;
          oidle_nxt = 1'b0;
          unique case (act_r)
            ACT_LOAD: begin
              pos_nxt  = load_r;
              wake_nxt = (due_r != '0) ? FIELD_W'(due_r) : '1;
            end
            ACT_IDLE: begin
              due_nxt   = '0;
              oidle_nxt = 1'b1;
              wake_nxt  = '1;
            end
            ACT_HOLD: begin
              wake_nxt = FIELD_W'(due_r);
            end
            ACT_STEP: begin
              due_nxt   = now_r + TIME_BITS'(interval);
              pos_nxt   = neg ? pos_r - POSITION_BITS'(1) : pos_r + POSITION_BITS'(1);
              dir_nxt   = ~neg;
              pulse_nxt = 1'b1;
              wake_nxt  = FIELD_W'(due_nxt);
            end
            default: begin
              wake_nxt = FIELD_W'(due_r);
            end
          endcase
          odir_nxt      = dir_nxt;
          opos_nxt      = FIELD_W'(pos_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_HOLD;
      due_r       <= '0;
      pos_r       <= '0;
      dir_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      due_r       <= due_nxt;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r  <= func_nxt;
    now_r   <= now_nxt;
    sum_r   <= sum_nxt;
    load_r  <= load_nxt;
    pulse_r <= pulse_nxt;
    odir_r  <= odir_nxt;
    opos_r  <= opos_nxt;
    wake_r  <= wake_nxt;
    oidle_r <= oidle_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_step_pulse   = pulse_r;
  assign out_direction    = odir_r;
  assign out_position     = opos_r;
  assign out_next_wake_us = wake_r;
  assign out_idle         = oidle_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished outside the wait state");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> !out_step_pulse && out_next_wake_us == '1)
    else $error("idle result carries a step or a wake time");

  a_div_only_for_step: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> state_r == S_DIV && act_r == ACT_STEP)
    else $error("divider running without a pending step");
`endif

endmodule
